// ===== rtl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image sampler.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Field widths of the beats on the ports
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 8;
  localparam int SAMPLE_W   = 20;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] IMAGE_DIM_RESET = 9'd256;

  // Image is split into four banks by row and column parity: bank = {y[0], x[0]}
  localparam int NUM_BANKS = 4;
  localparam int BANK_W    = 2;

  // Per-sample status carried alongside the fractions
  typedef struct packed {
    logic in_area;  // point lies in the interpolable area
    logic x_odd;    // parity of the integer column
    logic y_odd;    // parity of the integer row
  } bis_tag_t;

endpackage

// ===== rtl/bis_bank.sv =====
// ----------------------------------------------------------------------------
// bis_bank
// One image bank: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module bis_bank #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [bis_pkg::PIX_W-1:0]   wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [bis_pkg::PIX_W-1:0]   rd_data
);

  logic [bis_pkg::PIX_W-1:0] mem [DEPTH];
  logic [bis_pkg::PIX_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bis_front.sv =====
// ----------------------------------------------------------------------------
// bis_front
// Request decode: bounds check, split of the point into integer and fraction,
// bank read addresses for the four neighbors, bank select for pixel loads.
// ----------------------------------------------------------------------------
module bis_front #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8,
  parameter int AW        = 14
) (
  input  logic [bis_pkg::SAMPLE_W-1:0]   sample_x,
  input  logic [bis_pkg::SAMPLE_W-1:0]   sample_y,
  input  logic [bis_pkg::COORD_W-1:0]    pixel_x,
  input  logic [bis_pkg::COORD_W-1:0]    pixel_y,
  input  logic [bis_pkg::CFG_DATA_W-1:0] image_cols,
  input  logic [bis_pkg::CFG_DATA_W-1:0] image_rows,
  output bis_pkg::bis_tag_t              tag,
  output logic [FRAC_BITS-1:0]           frac_x,
  output logic [FRAC_BITS-1:0]           frac_y,
  output logic [bis_pkg::NUM_BANKS-1:0][AW-1:0] rd_addr,
  output logic [bis_pkg::NUM_BANKS-1:0]  wr_sel,
  output logic [AW-1:0]                  wr_addr
);

  localparam int IW      = bis_pkg::SAMPLE_W - FRAC_BITS;
  localparam int BCOLS   = (MAX_COLS + 1) / 2;
  localparam int BROWS   = (MAX_ROWS + 1) / 2;
  localparam int BCW     = (BCOLS > 1) ? $clog2(BCOLS) : 1;
  localparam int BRW     = (BROWS > 1) ? $clog2(BROWS) : 1;
  localparam int LIMW_C  = $clog2(MAX_COLS + 1);
  localparam int LIMW_R  = $clog2(MAX_ROWS + 1);
  localparam int CW0     = (IW + 1 > bis_pkg::CFG_DATA_W + 1) ? IW + 1 :
                           bis_pkg::CFG_DATA_W + 1;
  localparam int CW1     = (LIMW_C > CW0) ? LIMW_C : CW0;
  localparam int CMPW    = (LIMW_R > CW1) ? LIMW_R + 1 : CW1 + 1;

  logic [IW-1:0]   int_x;
  logic [IW-1:0]   int_y;
  logic [IW:0]     int_x_inc;
  logic [IW:0]     int_y_inc;
  logic [CMPW-1:0] cols_eff;
  logic [CMPW-1:0] rows_eff;
  logic            inside_x;
  logic            inside_y;
  logic [BCW-1:0]  bcol_even;
  logic [BCW-1:0]  bcol_odd;
  logic [BRW-1:0]  brow_even;
  logic [BRW-1:0]  brow_odd;
  logic            load_in_range;

  function automatic logic [AW-1:0] bank_addr(input logic [BRW-1:0] row,
                                               input logic [BCW-1:0] col);
    bank_addr = AW'(row * BCOLS + col);
  endfunction

  // Integer and fraction parts of the point
  assign int_x     = sample_x[bis_pkg::SAMPLE_W-1:FRAC_BITS];
  assign int_y     = sample_y[bis_pkg::SAMPLE_W-1:FRAC_BITS];
  assign frac_x    = sample_x[FRAC_BITS-1:0];
  assign frac_y    = sample_y[FRAC_BITS-1:0];
  assign int_x_inc = {1'b0, int_x} + (IW+1)'(1);
  assign int_y_inc = {1'b0, int_y} + (IW+1)'(1);

  // Image size clamped to the store
  assign cols_eff = (CMPW'(image_cols) > CMPW'(MAX_COLS)) ? CMPW'(MAX_COLS) :
                    CMPW'(image_cols);
  assign rows_eff = (CMPW'(image_rows) > CMPW'(MAX_ROWS)) ? CMPW'(MAX_ROWS) :
                    CMPW'(image_rows);

  // 0 <= x < cols-1 is the same as x >= 0 and floor(x)+1 < cols
  assign inside_x = !sample_x[bis_pkg::SAMPLE_W-1] && (CMPW'(int_x_inc) < cols_eff);
  assign inside_y = !sample_y[bis_pkg::SAMPLE_W-1] && (CMPW'(int_y_inc) < rows_eff);

  assign tag.in_area = inside_x && inside_y;
  assign tag.x_odd   = int_x[0];
  assign tag.y_odd   = int_y[0];

  // Even bank holds column (x+1)/2 when x is odd, x/2 when even
  assign bcol_even = BCW'(int_x_inc >> 1);
  assign bcol_odd  = BCW'(int_x >> 1);
  assign brow_even = BRW'(int_y_inc >> 1);
  assign brow_odd  = BRW'(int_y >> 1);

  always_comb begin
    for (int b = 0; b < bis_pkg::NUM_BANKS; b++) begin
      rd_addr[b] = bank_addr(b[1] ? brow_odd : brow_even,
                             b[0] ? bcol_odd : bcol_even);
    end
  end

  // Pixel load: one bank by parity, dropped outside the store
  assign load_in_range = (CMPW'(pixel_x) < CMPW'(MAX_COLS)) &&
                         (CMPW'(pixel_y) < CMPW'(MAX_ROWS));
  assign wr_addr = bank_addr(BRW'(pixel_y >> 1), BCW'(pixel_x >> 1));

  always_comb begin
    wr_sel = '0;
    wr_sel[{pixel_y[0], pixel_x[0]}] = load_in_range;
  end

endmodule

// ===== rtl/bis_interp.sv =====
// ----------------------------------------------------------------------------
// bis_interp
// Interpolation pipeline: weights, weighted pixels, sum and output register,
// each stage with its own valid bit and stall.
// ----------------------------------------------------------------------------
module bis_interp #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           a_valid,
  output logic                           a_advance,
  input  bis_pkg::bis_tag_t              a_tag,
  input  logic [FRAC_BITS-1:0]           a_frac_x,
  input  logic [FRAC_BITS-1:0]           a_frac_y,
  input  logic [bis_pkg::NUM_BANKS-1:0][bis_pkg::PIX_W-1:0] a_bank_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bis_pkg::OUT_W-1:0]      out_sample_value,
  output logic                           out_in_bounds
);

  localparam int FW = FRAC_BITS + 1;
  localparam int WW = 2 * FW;
  localparam int PW = WW + bis_pkg::PIX_W;
  localparam int SW = PW + 2;
  localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                      en_b;
  logic                      en_c;
  logic                      en_d;

  logic                      vb_r;
  logic                      vc_r;
  logic                      vd_r;
  logic                      in_b_r;
  logic                      in_c_r;
  logic                      in_d_r;
  logic [3:0][WW-1:0]        wgt_r;
  logic [3:0][bis_pkg::PIX_W-1:0] pix_r;
  logic [3:0][PW-1:0]        prod_r;
  logic [bis_pkg::OUT_W-1:0] value_r;

  logic [FW-1:0]             sfx;
  logic [FW-1:0]             sfy;
  logic [FW-1:0]             fx;
  logic [FW-1:0]             fy;
  logic [bis_pkg::BANK_W-1:0] b00;
  logic [bis_pkg::BANK_W-1:0] b01;
  logic [bis_pkg::BANK_W-1:0] b10;
  logic [bis_pkg::BANK_W-1:0] b11;
  logic [SW-1:0]             sum;

  // Stall chain from the output back to stage A
  assign en_d      = !vd_r || out_ready;
  assign en_c      = !vc_r || en_d;
  assign en_b      = !vb_r || en_c;
  assign a_advance = en_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_b) vb_r <= a_valid;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
    end
  end

  // Stage B: the four weights and the pixels in neighbor order
  assign fx  = {1'b0, a_frac_x};
  assign fy  = {1'b0, a_frac_y};
  assign sfx = ONE - fx;
  assign sfy = ONE - fy;
  assign b00 = {a_tag.y_odd, a_tag.x_odd};
  assign b01 = {a_tag.y_odd, !a_tag.x_odd};
  assign b10 = {!a_tag.y_odd, a_tag.x_odd};
  assign b11 = {!a_tag.y_odd, !a_tag.x_odd};

  always_ff @(posedge clk) begin
    if (en_b) begin
      in_b_r   <= a_tag.in_area;
      wgt_r[0] <= WW'(sfx) * WW'(sfy);
      wgt_r[1] <= WW'(fx) * WW'(sfy);
      wgt_r[2] <= WW'(sfx) * WW'(fy);
      wgt_r[3] <= WW'(fx) * WW'(fy);
      pix_r[0] <= a_bank_data[b00];
      pix_r[1] <= a_bank_data[b01];
      pix_r[2] <= a_bank_data[b10];
      pix_r[3] <= a_bank_data[b11];
    end
  end

  // Stage C: weighted pixels
  always_ff @(posedge clk) begin
    if (en_c) begin
      in_c_r <= in_b_r;
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= PW'(wgt_r[k]) * PW'(pix_r[k]);
      end
    end
  end

  // Stage D: sum, forced to zero outside the image
  assign sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + SW'(prod_r[3]);

  always_ff @(posedge clk) begin
    if (en_d) begin
      in_d_r  <= in_c_r;
      value_r <= in_c_r ? bis_pkg::OUT_W'(sum) : '0;
    end
  end

  assign out_valid        = vd_r;
  assign out_sample_value = value_r;
  assign out_in_bounds    = in_d_r;

endmodule

// ===== rtl/bilinear_image_sampler_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_sampler_core
// Grayscale image store with a bilinear point sampler.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while in_ready is high. A load beat writes
// one pixel and gives no result; a sample beat gives one result, through the
// bank read at the edge that takes it, then weights, products, sum. The image
// sits in four banks split by row and column parity, so the four neighbors of
// any point come from four different banks and are read in the same cycle,
// one read port each. Loads write at the cycle they are taken and samples read
// at the cycle they are taken, so every sample sees exactly the loads taken
// before it. Stages stall only when the output register is full and not taken;
// bubbles keep input open meanwhile. The store has no reset: pixels must be
// loaded before use.
// ----------------------------------------------------------------------------
module bilinear_image_sampler_core #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [bis_pkg::COORD_W-1:0]    in_pixel_x,
  input  logic [bis_pkg::COORD_W-1:0]    in_pixel_y,
  input  logic [bis_pkg::PIX_W-1:0]      in_pixel_value,
  input  logic [bis_pkg::SAMPLE_W-1:0]   in_sample_x,
  input  logic [bis_pkg::SAMPLE_W-1:0]   in_sample_y,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bis_pkg::OUT_W-1:0]      out_sample_value,
  output logic                           out_in_bounds,
  // Configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BCOLS = (MAX_COLS + 1) / 2;
  localparam int BROWS = (MAX_ROWS + 1) / 2;
  localparam int DEPTH = BCOLS * BROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bis_pkg::CFG_DATA_W-1:0] image_cols_r;
  logic [bis_pkg::CFG_DATA_W-1:0] image_rows_r;

  bis_pkg::bis_tag_t              tag;
  logic [FRAC_BITS-1:0]           frac_x;
  logic [FRAC_BITS-1:0]           frac_y;
  logic [bis_pkg::NUM_BANKS-1:0][AW-1:0] rd_addr;
  logic [bis_pkg::NUM_BANKS-1:0]  wr_sel;
  logic [bis_pkg::NUM_BANKS-1:0]  wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [bis_pkg::NUM_BANKS-1:0][bis_pkg::PIX_W-1:0] bank_data;

  logic                           in_beat;
  logic                           load_beat;
  logic                           sample_beat;
  logic                           a_advance;
  logic                           va_r;
  bis_pkg::bis_tag_t              tag_r;
  logic [FRAC_BITS-1:0]           frac_x_r;
  logic [FRAC_BITS-1:0]           frac_y_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_cols_r <= bis_pkg::IMAGE_DIM_RESET;
      image_rows_r <= bis_pkg::IMAGE_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bis_pkg::REG_IMAGE_COLS: image_cols_r <= cfg_wdata;
        bis_pkg::REG_IMAGE_ROWS: image_rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input handshake
  assign in_ready    = !va_r || a_advance;
  assign in_beat     = in_valid && in_ready;
  assign load_beat   = in_beat && (in_req_type == bis_pkg::REQ_LOAD);
  assign sample_beat = in_beat && (in_req_type == bis_pkg::REQ_SAMPLE);

  bis_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_front (
    .sample_x   (in_sample_x),
    .sample_y   (in_sample_y),
    .pixel_x    (in_pixel_x),
    .pixel_y    (in_pixel_y),
    .image_cols (image_cols_r),
    .image_rows (image_rows_r),
    .tag        (tag),
    .frac_x     (frac_x),
    .frac_y     (frac_y),
    .rd_addr    (rd_addr),
    .wr_sel     (wr_sel),
    .wr_addr    (wr_addr)
  );

  assign wr_en = wr_sel & {bis_pkg::NUM_BANKS{load_beat}};

  // Four parity banks
  for (genvar b = 0; b < bis_pkg::NUM_BANKS; b++) begin : g_bank
    bis_bank #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_en[b]),
      .wr_addr (wr_addr),
      .wr_data (in_pixel_value),
      .rd_en   (sample_beat),
      .rd_addr (rd_addr[b]),
      .rd_data (bank_data[b])
    );
  end

  // Stage A: sample status aligned with bank read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (sample_beat) begin
      va_r <= 1'b1;
    end else if (a_advance) begin
      va_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_beat) begin
      tag_r    <= tag;
      frac_x_r <= frac_x;
      frac_y_r <= frac_y;
    end
  end

  bis_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk              (clk),
    .rst_n            (rst_n),
    .a_valid          (va_r),
    .a_advance        (a_advance),
    .a_tag            (tag_r),
    .a_frac_x         (frac_x_r),
    .a_frac_y         (frac_y_r),
    .a_bank_data      (bank_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_in_bounds    (out_in_bounds)
  );

`ifndef SYNTH
  // A load touches at most one bank
  a_one_bank_write: assert property (@(posedge clk) $onehot0(wr_en))
    else $error("load wrote more than one bank");

  // Input only closes when the whole pipeline is full behind a stalled output
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // A taken sample always occupies stage A next cycle
  a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
    sample_beat |=> va_r)
    else $error("sample beat lost at stage A");

  // Out-of-bounds results carry zero
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_bounds) |-> (out_sample_value == '0))
    else $error("nonzero value on out-of-bounds result");
`endif

endmodule

// ===== verif/bis_sample_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_sample_checker
// Passive scoreboard for the bilinear sampler. It mirrors every register
// write and pixel load into a shadow image, predicts the interpolated value
// of each sample beat, and compares the results in order.
// ----------------------------------------------------------------------------
module bis_sample_checker #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [bis_pkg::COORD_W-1:0]    in_pixel_x,
  input  logic [bis_pkg::COORD_W-1:0]    in_pixel_y,
  input  logic [bis_pkg::PIX_W-1:0]      in_pixel_value,
  input  logic [bis_pkg::SAMPLE_W-1:0]   in_sample_x,
  input  logic [bis_pkg::SAMPLE_W-1:0]   in_sample_y,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [bis_pkg::OUT_W-1:0]      out_sample_value,
  input  logic                           out_in_bounds,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    pending_results,
  output int unsigned                    mismatches
);

  localparam int ONE = 1 << FRAC_BITS;

  typedef struct packed {
    logic [bis_pkg::OUT_W-1:0] value;
    logic                      in_bounds;
  } sample_result_t;

  logic [bis_pkg::PIX_W-1:0]      shadow_img [MAX_COLS*MAX_ROWS];
  logic [bis_pkg::CFG_DATA_W-1:0] cols_reg;
  logic [bis_pkg::CFG_DATA_W-1:0] rows_reg;
  sample_result_t                 expected_q [$];

  function automatic int stored_pixel(input int x, input int y);
    return int'(shadow_img[y * MAX_COLS + x]);
  endfunction

  // Exact bilinear blend of the four neighbors; zero outside the usable area
  function automatic sample_result_t interpolate(
      input logic [bis_pkg::SAMPLE_W-1:0] sx_raw,
      input logic [bis_pkg::SAMPLE_W-1:0] sy_raw);
    int             xs, ys, c, r, tx, ty, fx, fy;
    longint         acc;
    sample_result_t res;
    xs  = $signed(sx_raw);
    ys  = $signed(sy_raw);
    c   = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    r   = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    res = '0;
    if (xs >= 0 && ys >= 0 && xs < (c - 1) * ONE && ys < (r - 1) * ONE) begin
      tx  = xs / ONE;
      ty  = ys / ONE;
      fx  = xs % ONE;
      fy  = ys % ONE;
      acc = longint'((ONE - fx) * (ONE - fy)) * stored_pixel(tx, ty)
          + longint'(fx * (ONE - fy)) * stored_pixel(tx + 1, ty)
          + longint'((ONE - fx) * fy) * stored_pixel(tx, ty + 1)
          + longint'(fx * fy) * stored_pixel(tx + 1, ty + 1);
      res.value     = acc[bis_pkg::OUT_W-1:0];
      res.in_bounds = 1'b1;
    end
    return res;
  endfunction

  // Results leaving, then beats entering, then register writes
  always @(posedge clk) begin : watch
    sample_result_t want;
    if (!rst_n) begin
      cols_reg   = bis_pkg::IMAGE_DIM_RESET;
      rows_reg   = bis_pkg::IMAGE_DIM_RESET;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat expected none, actual value %0h in_bounds %0b",
                   $time, out_sample_value, out_in_bounds);
        end else begin
          want = expected_q.pop_front();
          if (out_sample_value !== want.value) begin
            mismatches++;
            $display("%0t: sample_value expected %0h actual %0h",
                     $time, want.value, out_sample_value);
          end
          if (out_in_bounds !== want.in_bounds) begin
            mismatches++;
            $display("%0t: in_bounds expected %0b actual %0b",
                     $time, want.in_bounds, out_in_bounds);
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_req_type == bis_pkg::REQ_SAMPLE) begin
          expected_q.insert(expected_q.size(), interpolate(in_sample_x, in_sample_y));
        end else if (in_pixel_x < MAX_COLS && in_pixel_y < MAX_ROWS) begin
          shadow_img[int'(in_pixel_y) * MAX_COLS + int'(in_pixel_x)] = in_pixel_value;
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bis_pkg::REG_IMAGE_COLS) cols_reg = cfg_wdata;
        else if (cfg_index == bis_pkg::REG_IMAGE_ROWS) rows_reg = cfg_wdata;
      end
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== verif/bilinear_image_sampler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_sampler_core_tb
// Drives pixel loads and sample points into the sampler under random gaps
// and back-pressure, across several image sizes including degenerate and
// oversized ones. Samples that land inside the image only touch pixel quads
// that were loaded earlier. Checking is done by bis_sample_checker.
// ----------------------------------------------------------------------------
module bilinear_image_sampler_core_tb;

  localparam int RANDOM_ITEMS = 1850;
  localparam int NUM_PHASES   = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_STALL   = 300;
  localparam int STALL_AFTER  = 200;
  localparam int IMG_DIM      = 256;
  localparam int FRAC_ONE     = 256;

  // Indexes past the register list; writes there must be dropped
  localparam logic [bis_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic                           in_req_type    = bis_pkg::REQ_LOAD;
  logic [bis_pkg::COORD_W-1:0]    in_pixel_x     = '0;
  logic [bis_pkg::COORD_W-1:0]    in_pixel_y     = '0;
  logic [bis_pkg::PIX_W-1:0]      in_pixel_value = '0;
  logic [bis_pkg::SAMPLE_W-1:0]   in_sample_x    = '0;
  logic [bis_pkg::SAMPLE_W-1:0]   in_sample_y    = '0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic [bis_pkg::OUT_W-1:0]      out_sample_value;
  logic                           out_in_bounds;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index      = bis_pkg::REG_IMAGE_COLS;
  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;

  int unsigned pending_results;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  bit          send_calm   = 1'b0;
  bit          recv_calm   = 1'b0;

  // Register values as last written, for picking legal sample points
  logic [bis_pkg::CFG_DATA_W-1:0] cur_cols = bis_pkg::IMAGE_DIM_RESET;
  logic [bis_pkg::CFG_DATA_W-1:0] cur_rows = bis_pkg::IMAGE_DIM_RESET;

  // Loaded pixels and the 2x2 quads that are fully loaded ({ty, tx})
  bit          pix_loaded  [IMG_DIM*IMG_DIM];
  bit          quad_listed [IMG_DIM*IMG_DIM];
  logic [15:0] quad_anchors [$];

  always #5 clk = ~clk;

  bilinear_image_sampler_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_pixel_value   (in_pixel_value),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_in_bounds    (out_in_bounds),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  bis_sample_checker sample_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_pixel_value   (in_pixel_value),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_in_bounds    (out_in_bounds),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pending_results  (pending_results),
    .mismatches       (mismatches)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int eff_dim(input logic [bis_pkg::CFG_DATA_W-1:0] d);
    return (d > IMG_DIM) ? IMG_DIM : int'(d);
  endfunction

  // Byte biased toward its extremes
  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Coordinate for a probe; with keep_out set it never lands in the usable range
  function automatic logic [bis_pkg::SAMPLE_W-1:0] probe_coord(
      input logic [bis_pkg::CFG_DATA_W-1:0] d,
      input bit                             keep_out);
    logic [bis_pkg::SAMPLE_W-1:0] v;
    int                           lim;
    lim = (eff_dim(d) - 1) * FRAC_ONE;
    case ($urandom_range(0, 4))
      0:       v = 20'hFFFFF;
      1:       v = bis_pkg::SAMPLE_W'(lim);
      2:       v = 20'h7FFFF;
      3:       v = 20'h80000;
      default: v = bis_pkg::SAMPLE_W'($urandom);
    endcase
    if (keep_out && int'($signed(v)) >= 0 && int'($signed(v)) < lim)
      v[bis_pkg::SAMPLE_W-1] = 1'b1;
    return v;
  endfunction

  // One request beat: optional gap, then hold valid until taken
  task automatic send_beat(input logic req, input logic [7:0] px, input logic [7:0] py,
                           input logic [7:0] pv, input logic [bis_pkg::SAMPLE_W-1:0] sx,
                           input logic [bis_pkg::SAMPLE_W-1:0] sy);
    int gap;
    if ($urandom_range(0, 23) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_pixel_x     <= px;
    in_pixel_y     <= py;
    in_pixel_value <= pv;
    in_sample_x    <= sx;
    in_sample_y    <= sy;
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic sample_beat(input logic [bis_pkg::SAMPLE_W-1:0] sx,
                             input logic [bis_pkg::SAMPLE_W-1:0] sy);
    send_beat(bis_pkg::REQ_SAMPLE, 8'($urandom), 8'($urandom), 8'($urandom), sx, sy);
  endtask

  // Load one pixel and list every quad it completes
  task automatic load_pixel(input logic [7:0] x, input logic [7:0] y, input logic [7:0] v);
    int ax, ay, base;
    pix_loaded[{y, x}] = 1'b1;
    for (ay = int'(y) - 1; ay <= int'(y); ay++) begin
      for (ax = int'(x) - 1; ax <= int'(x); ax++) begin
        base = ay * IMG_DIM + ax;
        if (ax >= 0 && ay >= 0 && ax < IMG_DIM - 1 && ay < IMG_DIM - 1) begin
          if (!quad_listed[base] && pix_loaded[base] && pix_loaded[base + 1] &&
              pix_loaded[base + IMG_DIM] && pix_loaded[base + IMG_DIM + 1]) begin
            quad_listed[base] = 1'b1;
            quad_anchors.insert(quad_anchors.size(), {8'(ay), 8'(ax)});
          end
        end
      end
    end
    send_beat(bis_pkg::REQ_LOAD, x, y, v, bis_pkg::SAMPLE_W'($urandom),
              bis_pkg::SAMPLE_W'($urandom));
  endtask

  // Out-of-area point: one coordinate is forced out, the other is free
  task automatic sample_probe();
    bit x_out;
    x_out = $urandom_range(0, 1);
    sample_beat(probe_coord(cur_cols, x_out), probe_coord(cur_rows, !x_out));
  endtask

  // Point inside a loaded quad that the current size allows; recent quads favored
  task automatic sample_inside();
    int          c, r, k, idx, tries;
    logic [15:0] a;
    bit          found;
    c     = eff_dim(cur_cols);
    r     = eff_dim(cur_rows);
    found = 1'b0;
    a     = '0;
    for (tries = 0; tries < 12 && !found && quad_anchors.size() > 0; tries++) begin
      k = quad_anchors.size();
      if ($urandom_range(0, 1)) idx = k - 1 - $urandom_range(0, (k > 8) ? 8 : k - 1);
      else idx = $urandom_range(0, k - 1);
      a     = quad_anchors[idx];
      found = (int'(a[7:0]) <= c - 2) && (int'(a[15:8]) <= r - 2);
    end
    if (found) sample_beat({4'b0, a[7:0], edge_byte()}, {4'b0, a[15:8], edge_byte()});
    else sample_probe();
  endtask

  // Small patch of pixels, often against the right or bottom edge of the image
  task automatic load_patch();
    int c, r, w, h, x0, y0, i, j;
    c = eff_dim(cur_cols);
    r = eff_dim(cur_rows);
    if (c < 2) c = IMG_DIM;
    if (r < 2) r = IMG_DIM;
    w  = $urandom_range(2, 4);
    h  = $urandom_range(2, 4);
    if (w > c) w = c;
    if (h > r) h = r;
    x0 = ($urandom_range(0, 3) == 0) ? c - w : $urandom_range(0, c - w);
    y0 = ($urandom_range(0, 3) == 0) ? r - h : $urandom_range(0, r - h);
    for (j = 0; j < h; j++) begin
      for (i = 0; i < w; i++) begin
        load_pixel(8'(x0 + i), 8'(y0 + j), edge_byte());
      end
    end
  endtask

  // Mostly load-then-sample sequences, plus stray probes and loose loads
  task automatic random_burst();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      load_patch();
      repeat ($urandom_range(2, 8)) sample_inside();
    end else if (roll < 80) begin
      repeat ($urandom_range(1, 6)) sample_inside();
    end else if (roll < 92) begin
      sample_probe();
    end else begin
      load_pixel(8'($urandom), 8'($urandom), edge_byte());
    end
  endtask

  // One register write; valid drops after it is taken, before the next write
  task automatic write_reg(input logic [bis_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [bis_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    while (cfg_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == bis_pkg::REG_IMAGE_COLS) cur_cols = data;
    else if (idx == bis_pkg::REG_IMAGE_ROWS) cur_rows = data;
    @(posedge clk);
  endtask

  // Stop sending and wait out every outstanding result plus pipeline slack
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  // Result side: random stalls, calm stretches, one long hold-off
  initial begin : result_sink
    int          gap;
    int unsigned taken;
    taken = 0;
    @(negedge clk);
    while (rst_n !== 1'b1) @(negedge clk);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 18);
      if (taken == STALL_AFTER) gap = LONG_STALL;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (out_valid !== 1'b1) @(negedge clk);
      @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    logic [bis_pkg::CFG_DATA_W-1:0] col_set [NUM_PHASES];
    logic [bis_pkg::CFG_DATA_W-1:0] row_set [NUM_PHASES];
    int                             ph, quota;

    // Full, minimal, strip, degenerate, oversized and odd sizes
    col_set = '{9'd256, 9'd2, 9'd2, 9'd256, 9'd0, 9'd1, 9'd511, 9'd37, 9'd0};
    row_set = '{9'd256, 9'd2, 9'd256, 9'd2, 9'd1, 9'd0, 9'd300, 9'd11, 9'd0};
    col_set[NUM_PHASES-1] = bis_pkg::CFG_DATA_W'($urandom_range(2, 256));
    row_set[NUM_PHASES-1] = bis_pkg::CFG_DATA_W'($urandom_range(2, 256));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner quads, fraction extremes, area edges, sign extremes
    load_pixel(8'd0, 8'd0, 8'd0);
    load_pixel(8'd1, 8'd0, 8'd255);
    load_pixel(8'd0, 8'd1, 8'd128);
    load_pixel(8'd1, 8'd1, 8'd1);
    load_pixel(8'd254, 8'd254, 8'd255);
    load_pixel(8'd255, 8'd254, 8'd255);
    load_pixel(8'd254, 8'd255, 8'd255);
    load_pixel(8'd255, 8'd255, 8'd255);
    sample_beat(20'h00000, 20'h00000);
    sample_beat(20'h00080, 20'h00080);
    sample_beat(20'h000FF, 20'h000FF);
    sample_beat(20'h0FEFF, 20'h0FEFF);   // largest in-area point, peak value
    sample_beat(20'h0FF00, 20'h0FE00);   // one step past the right edge
    sample_beat(20'h0FE00, 20'h0FF00);   // one step past the bottom edge
    sample_beat(20'hFFFFF, 20'h00000);
    sample_beat(20'h00000, 20'hFFFFF);
    sample_beat(20'h80000, 20'h7FFFF);
    sample_beat(20'h7FFFF, 20'h80000);
    load_pixel(8'd0, 8'd0, 8'd255);      // overwrite, then read right behind it
    sample_beat(20'h00040, 20'h00000);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(bis_pkg::REG_IMAGE_COLS, col_set[ph]);
      write_reg(bis_pkg::REG_IMAGE_ROWS, row_set[ph]);
      if (ph == 3) begin
        write_reg(REG_SPARE_A, bis_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, bis_pkg::CFG_DATA_W'($urandom));
      end
      quota = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < quota) random_burst();
      drain();
    end

    if (mismatches == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bis_pkg.sv
rtl/bis_bank.sv
rtl/bis_front.sv
rtl/bis_interp.sv
rtl/bilinear_image_sampler_core.sv
verif/bis_sample_checker.sv
verif/bilinear_image_sampler_core_tb.sv
